### src/mmfm_pkg.sv
// ----------------------------------------------------------------------------
// mmfm_pkg
// Shared types, constants and helpers for the multi-marker first-match search.
// ----------------------------------------------------------------------------
package mmfm_pkg;

    localparam int MARKERS    = 4;
    localparam int MARKER_LEN = 8;
    localparam int MAX_TEXT   = 65536;

    localparam int MARKER_REGS = 4;
    localparam int ACTIVE_MAX  = (MARKERS < MARKER_REGS) ? MARKERS : MARKER_REGS;
    localparam int BYTE_W      = 8;
    localparam int MARKER_W    = 64;
    localparam int LEN_W       = 4;
    localparam int IDX_W       = 2;
    localparam int COUNT_W     = 3;
    localparam int LENGTHS_W   = 16;
    localparam int POSITION_W  = 16;
    localparam int TEXT_POS_W  = $clog2(MAX_TEXT) + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int WIN_IDX_W   = (MARKER_LEN > 1) ? $clog2(MARKER_LEN) : 1;

    localparam logic [LENGTHS_W-1:0] LENGTHS_RESET = 16'h1111;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef byte_t [MARKER_LEN-1:0] window_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNT    = 3'd0,
        REG_MARKER_0 = 3'd1,
        REG_MARKER_1 = 3'd2,
        REG_MARKER_2 = 3'd3,
        REG_MARKER_3 = 3'd4,
        REG_LENGTHS  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                    count;
        logic [MARKER_REGS-1:0][MARKER_W-1:0]  markers;
        logic [LENGTHS_W-1:0]                  lengths;
    } cfg_t;

    // length field clipped to the window size
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] field);
        logic [LEN_W-1:0] res;
        if (32'(field) > MARKER_LEN)
            res = LEN_W'(MARKER_LEN);
        else
            res = field;
        return res;
    endfunction

endpackage

### src/mmfm_cfg.sv
// ----------------------------------------------------------------------------
// mmfm_cfg
// Configuration register file: marker count, marker bytes and lengths.
// ----------------------------------------------------------------------------
module mmfm_cfg
    import mmfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MARKER_W-1:0]  cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COUNT:    cfg_next.count      = cfg_data[COUNT_W-1:0];
                REG_MARKER_0: cfg_next.markers[0] = cfg_data;
                REG_MARKER_1: cfg_next.markers[1] = cfg_data;
                REG_MARKER_2: cfg_next.markers[2] = cfg_data;
                REG_MARKER_3: cfg_next.markers[3] = cfg_data;
                REG_LENGTHS:  cfg_next.lengths    = cfg_data[LENGTHS_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count   <= '0;
            cfg_reg.markers <= '0;
            cfg_reg.lengths <= LENGTHS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/mmfm_match.sv
// ----------------------------------------------------------------------------
// mmfm_match
// Compares one marker against the newest bytes of the window.
// ----------------------------------------------------------------------------
module mmfm_match
    import mmfm_pkg::*;
(
    input  window_t             window,
    input  logic [MARKER_W-1:0] marker,
    input  logic [LEN_W-1:0]    len,
    output logic                hit
);

    always_comb
    begin
        logic [WIN_IDX_W-1:0] w;
        hit = (len != '0);
        for (int j = 0; j < MARKER_LEN; j++)
        begin
            // marker byte j lines up with the byte len-1-j steps back
            w = WIN_IDX_W'(32'(len) - 1 - j);
            if (j < 32'(len))
            begin
                if (window[w] != marker[BYTE_W*j +: BYTE_W])
                    hit = 1'b0;
            end
        end
    end

endmodule

### src/multi_marker_first_match.sv
// ----------------------------------------------------------------------------
// multi_marker_first_match
// Streaming earliest-match search for up to four configured markers.
// ----------------------------------------------------------------------------
// Takes one text word per cycle (in_valid/in_ready) into an input register; the
// next cycle all markers are compared in parallel against an eight-byte window
// and the best match so far is updated, so the sustained rate is one byte per
// clock. A word with last_byte set loads the result register once that is free;
// the result is held until out_ready. Input stalls only when a final word meets a
// full result register. Configuration (cfg_write/cfg_index/cfg_data) is to be
// written by the user only while no text is in flight; the block does not check.
// ----------------------------------------------------------------------------
module multi_marker_first_match
    import mmfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [MARKER_W-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     text_byte,
    input  logic                  last_byte,
    input  logic [POSITION_W-1:0] search_from,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [POSITION_W-1:0] match_position,
    output logic [LEN_W-1:0]      match_length,
    output logic [IDX_W-1:0]      marker_index
);

    cfg_t cfg;

    mmfm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    logic                  s1_valid_reg;
    logic [BYTE_W-1:0]     s1_byte_reg;
    logic                  s1_last_reg;
    logic [POSITION_W-1:0] s1_from_reg;

    // search state
    window_t               window_reg;
    logic [TEXT_POS_W-1:0] text_pos_reg;
    logic [POSITION_W-1:0] start_limit_reg;
    logic                  best_found_reg;
    logic [POSITION_W-1:0] best_start_reg;
    logic [IDX_W-1:0]      best_marker_reg;
    logic [LEN_W-1:0]      best_len_reg;

    // result register
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [POSITION_W-1:0] position_reg;
    logic [LEN_W-1:0]      length_reg;
    logic [IDX_W-1:0]      index_reg;

    logic                  out_free;
    logic                  s1_fire;
    logic                  in_fire;

    window_t               window_next;
    logic [TEXT_POS_W-1:0] text_pos_next;
    logic [POSITION_W-1:0] limit_cur;
    logic                  examine;
    logic [COUNT_W:0]      active;
    logic [LEN_W-1:0]      lens   [MARKER_REGS];
    logic [MARKER_REGS-1:0] hits;
    logic                  best_found_next;
    logic [POSITION_W-1:0] best_start_next;
    logic [IDX_W-1:0]      best_marker_next;
    logic [LEN_W-1:0]      best_len_next;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        window_next[0] = s1_byte_reg;
        for (int i = 1; i < MARKER_LEN; i++)
            window_next[i] = window_reg[i-1];
    end

    assign examine   = (32'(text_pos_reg) < MAX_TEXT);
    assign limit_cur = (text_pos_reg == '0) ? s1_from_reg : start_limit_reg;
    assign active    = (32'(cfg.count) > ACTIVE_MAX) ? (COUNT_W+1)'(ACTIVE_MAX)
                                                     : {1'b0, cfg.count};
    assign text_pos_next = examine ? text_pos_reg + 1'b1 : text_pos_reg;

    for (genvar u = 0; u < MARKER_REGS; u++)
    begin : g_marker
        assign lens[u] = sat_len(cfg.lengths[LEN_W*u +: LEN_W]);

        mmfm_match u_match (
            .window (window_next),
            .marker (cfg.markers[u]),
            .len    (lens[u]),
            .hit    (hits[u])
        );
    end

    always_comb
    begin
        logic [TEXT_POS_W-1:0] start_wide;
        logic [POSITION_W-1:0] start;
        logic                  ok;
        best_found_next  = best_found_reg;
        best_start_next  = best_start_reg;
        best_marker_next = best_marker_reg;
        best_len_next    = best_len_reg;
        for (int u = 0; u < MARKER_REGS; u++)
        begin
            start_wide = text_pos_reg + 1'b1 - TEXT_POS_W'(lens[u]);
            start      = start_wide[POSITION_W-1:0];
            ok = examine && (u < 32'(active)) && hits[u]
                && (text_pos_reg + 1'b1 >= TEXT_POS_W'(lens[u]))
                && (start >= limit_cur);
            // equal starts go to the lower index
            if (ok && (!best_found_next || start < best_start_next
                       || (start == best_start_next && IDX_W'(u) < best_marker_next)))
            begin
                best_found_next  = 1'b1;
                best_start_next  = start;
                best_marker_next = IDX_W'(u);
                best_len_next    = lens[u];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= last_byte;
            s1_from_reg <= search_from;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            text_pos_reg    <= '0;
            start_limit_reg <= '0;
            best_found_reg  <= 1'b0;
            best_start_reg  <= '0;
            best_marker_reg <= '0;
            best_len_reg    <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                window_reg      <= '0;
                text_pos_reg    <= '0;
                start_limit_reg <= '0;
                best_found_reg  <= 1'b0;
                best_start_reg  <= '0;
                best_marker_reg <= '0;
                best_len_reg    <= '0;
            end
            else
            begin
                if (examine)
                    window_reg <= window_next;
                text_pos_reg    <= text_pos_next;
                start_limit_reg <= limit_cur;
                best_found_reg  <= best_found_next;
                best_start_reg  <= best_start_next;
                best_marker_reg <= best_marker_next;
                best_len_reg    <= best_len_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            found_reg    <= best_found_next;
            position_reg <= best_found_next ? best_start_next : '0;
            length_reg   <= best_found_next ? best_len_next : '0;
            index_reg    <= best_found_next ? best_marker_next : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_position = position_reg;
    assign match_length   = length_reg;
    assign marker_index   = index_reg;

    a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> out_valid_reg)
        else $error("final word did not load the result register");

    a_last_clears_text: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (text_pos_reg == '0 && !best_found_reg))
        else $error("search state not cleared after final word");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |->
            (position_reg == '0 && length_reg == '0 && index_reg == '0))
        else $error("miss result carries nonzero fields");

    a_hit_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (length_reg != '0))
        else $error("match reported with zero length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(s1_fire && s1_last_reg))
        else $error("result overwritten while held");

endmodule

### test/multi_marker_first_match_tb.sv
// ----------------------------------------------------------------------------
// multi_marker_first_match_tb
// Self-checking testbench for the streaming multi-marker first-match search.
// ----------------------------------------------------------------------------
// Texts are streamed one word per handshake. A built-in tracker follows each
// accepted word: window, position, start offset and best match. It queues the
// result expected on every final word. Directed texts cover the register
// extremes, ties, zero bytes, oversized markers and markers longer than the
// text. Random phases then reprogram the markers and stream texts with markers
// embedded in them. Sender bursts and receiver stalls are randomized throughout.
// ----------------------------------------------------------------------------
module multi_marker_first_match_tb;
    import mmfm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        byte_t                 text;
        logic                  is_last;
        logic [POSITION_W-1:0] start_from;
    } text_word_t;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
        logic [LEN_W-1:0]      length;
        logic [IDX_W-1:0]      index;
    } match_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [MARKER_W-1:0]   cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     text_byte = '0;
    logic                  last_byte = 1'b0;
    logic [POSITION_W-1:0] search_from = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  found;
    logic [POSITION_W-1:0] match_position;
    logic [LEN_W-1:0]      match_length;
    logic [IDX_W-1:0]      marker_index;

    multi_marker_first_match dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .text_byte      (text_byte),
        .last_byte      (last_byte),
        .search_from    (search_from),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_position (match_position),
        .match_length   (match_length),
        .marker_index   (marker_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register shadow
    logic [COUNT_W-1:0]   cfg_count = '0;
    logic [MARKER_W-1:0]  cfg_marker [MARKER_REGS] = '{default: '0};
    logic [LENGTHS_W-1:0] cfg_lengths = LENGTHS_RESET;

    // search tracker state
    byte_t       trk_window [MARKER_LEN] = '{default: '0};
    int unsigned trk_pos = 0;
    int unsigned trk_limit = 0;
    bit          trk_hit = 1'b0;
    int unsigned trk_start = 0;
    int unsigned trk_marker = 0;
    int unsigned trk_len = 0;

    text_word_t  text_words [$];
    match_word_t matches_due [$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          max_gap = 3;
    logic        in_accepted = 1'b0;

    task automatic track_byte(input byte_t b, input logic is_last,
                              input logic [POSITION_W-1:0] start_from);
        int unsigned active;
        int unsigned len;
        int unsigned start;
        int          i;
        int          u;
        int          j;
        bit          hit;
        match_word_t res;
        if (trk_pos == 0)
            trk_limit = start_from;
        active = cfg_count;
        if (active > ACTIVE_MAX)
            active = ACTIVE_MAX;
        if (trk_pos < MAX_TEXT)
        begin
            for (i = MARKER_LEN - 1; i > 0; i--)
                trk_window[i] = trk_window[i-1];
            trk_window[0] = b;
            for (u = 0; u < int'(active); u++)
            begin
                len = cfg_lengths[4*u +: 4];
                if (len > MARKER_LEN)
                    len = MARKER_LEN;
                if (len != 0 && trk_pos + 1 >= len)
                begin
                    start = trk_pos + 1 - len;
                    hit = (start >= trk_limit);
                    for (j = 0; j < int'(len); j++)
                        if (trk_window[len-1-j] != cfg_marker[u][8*j +: 8])
                            hit = 1'b0;
                    if (hit && (!trk_hit || start < trk_start ||
                                (start == trk_start && u < int'(trk_marker))))
                    begin
                        trk_hit = 1'b1;
                        trk_start = start;
                        trk_marker = u;
                        trk_len = len;
                    end
                end
            end
            trk_pos = trk_pos + 1;
        end
        if (is_last)
        begin
            res.found = trk_hit;
            res.position = trk_hit ? POSITION_W'(trk_start) : '0;
            res.length = trk_hit ? LEN_W'(trk_len) : '0;
            res.index = trk_hit ? IDX_W'(trk_marker) : '0;
            matches_due.push_back(res);
            trk_window = '{default: '0};
            trk_pos = 0;
            trk_limit = 0;
            trk_hit = 1'b0;
            trk_start = 0;
            trk_marker = 0;
            trk_len = 0;
        end
    endtask

    // driver
    text_word_t next_word;
    int         burst_left = 0;
    int         idle_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_accepted)
        begin
            if (idle_left != 0 || text_words.size() == 0)
            begin
                if (idle_left != 0)
                    idle_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_word = text_words.pop_front();
                text_byte <= next_word.text;
                last_byte <= next_word.is_last;
                search_from <= next_word.start_from;
                in_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    idle_left = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
                end
            end
        end
    end

    // receiver stall pattern
    logic [15:0] stall_bits = '1;
    logic [3:0]  stall_step = '0;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_step == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_bits = '1;
                    1: stall_bits = 16'($urandom);
                    2: stall_bits = 16'($urandom | $urandom);
                    default: stall_bits = 16'($urandom & $urandom);
                endcase
            end
            out_ready <= stall_bits[stall_step];
            stall_step = stall_step + 1'b1;
        end
    end

    // monitor
    match_word_t due;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_accepted <= 1'b0;
        end
        else if (cycles >= CYCLE_LIMIT)
        begin
            $display("multi_marker_first_match regression: fail");
            $finish;
        end
        else
        begin
            cycles++;
            in_accepted <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                words_taken++;
                track_byte(text_byte, last_byte, search_from);
            end
            if (out_valid && out_ready)
            begin
                if (matches_due.size() == 0)
                begin
                    $error("result word with nothing due: found %0d position %0d",
                           found, match_position);
                    mismatches++;
                end
                else
                begin
                    due = matches_due.pop_front();
                    if (found !== due.found)
                    begin
                        $error("found: expected %0d, actual %0d", due.found, found);
                        mismatches++;
                    end
                    if (match_position !== due.position)
                    begin
                        $error("match_position: expected %0d, actual %0d",
                               due.position, match_position);
                        mismatches++;
                    end
                    if (match_length !== due.length)
                    begin
                        $error("match_length: expected %0d, actual %0d",
                               due.length, match_length);
                        mismatches++;
                    end
                    if (marker_index !== due.index)
                    begin
                        $error("marker_index: expected %0d, actual %0d",
                               due.index, marker_index);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [MARKER_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_COUNT: cfg_count = data[COUNT_W-1:0];
            REG_MARKER_0, REG_MARKER_1, REG_MARKER_2, REG_MARKER_3:
                cfg_marker[int'(idx) - int'(REG_MARKER_0)] = data;
            REG_LENGTHS: cfg_lengths = data[LENGTHS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_word(input byte_t b, input logic is_last,
                              input logic [POSITION_W-1:0] start_from);
        text_word_t w;
        w.text = b;
        w.is_last = is_last;
        w.start_from = start_from;
        text_words.push_back(w);
        words_queued++;
    endtask

    function automatic byte_t pick_byte();
        int    u;
        int    l;
        int    k;
        byte_t b;
        u = $urandom_range(0, MARKER_REGS - 1);
        l = cfg_lengths[4*u +: 4];
        if (l == 0 || l > MARKER_LEN)
            l = MARKER_LEN;
        k = $urandom_range(0, l - 1);
        if ($urandom_range(0, 3) == 0)
            b = byte_t'($urandom);
        else
            b = cfg_marker[u][8*k +: 8];
        return b;
    endfunction

    // random text with markers dropped in at random offsets, cut off at the text end
    task automatic queue_text(input int n, input logic [POSITION_W-1:0] start_from);
        byte_t txt [$];
        int    u;
        int    l;
        int    at;
        int    k;
        for (k = 0; k < n; k++)
            txt.push_back(pick_byte());
        repeat ($urandom_range(0, 2))
        begin
            u = $urandom_range(0, MARKER_REGS - 1);
            l = cfg_lengths[4*u +: 4];
            if (l == 0 || l > MARKER_LEN)
                l = MARKER_LEN;
            at = $urandom_range(0, n - 1);
            for (k = 0; k < l && at + k < n; k++)
                txt[at+k] = cfg_marker[u][8*k +: 8];
        end
        for (k = 0; k < n; k++)
            queue_word(txt[k], k == n - 1,
                       (k == 0) ? start_from : POSITION_W'($urandom));
    endtask

    task automatic new_search_setup();
        logic [MARKER_W-1:0]  m;
        logic [LENGTHS_W-1:0] lens;
        int                   style;
        int                   u;
        int                   k;
        for (u = 0; u < MARKER_REGS; u++)
        begin
            style = $urandom_range(0, 9);
            for (k = 0; k < MARKER_LEN; k++)
            begin
                case ($urandom_range(0, 3))
                    0: m[8*k +: 8] = 8'h00;
                    1: m[8*k +: 8] = 8'h41;
                    2: m[8*k +: 8] = 8'h42;
                    default: m[8*k +: 8] = 8'hFF;
                endcase
                if (style >= 7)
                    m[8*k +: 8] = byte_t'($urandom);
            end
            if (style == 0)
                m = '0;
            else if (style == 1)
                m = '1;
            cfg_put(CFG_IDX_W'(int'(REG_MARKER_0) + u), m);
        end
        case ($urandom_range(0, 7))
            0: lens = 16'h0000;
            1: lens = 16'hFFFF;
            2: lens = 16'h8888;
            default:
                for (k = 0; k < 4; k++)
                    lens[4*k +: 4] = ($urandom_range(0, 3) == 0) ?
                        LEN_W'($urandom_range(0, 15)) : LEN_W'($urandom_range(1, 4));
        endcase
        cfg_put(REG_LENGTHS, lens);
        cfg_put(($urandom_range(0, 1) == 0) ? REG_SPARE_6 : REG_SPARE_7, MARKER_W'($urandom));
        cfg_put(REG_COUNT, ($urandom_range(0, 4) == 0) ?
                COUNT_W'($urandom_range(0, 7)) : COUNT_W'($urandom_range(1, 4)));
        cfg_done();
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || matches_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int                    ph;
        int                    target;
        int                    n;
        int                    k;
        logic [POSITION_W-1:0] from;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: no active markers
        queue_word(8'h41, 1'b1, 16'h0000);
        wait_idle();

        // two-byte, one-byte and all-zero markers; a longer marker ties a shorter one
        cfg_put(REG_MARKER_0, 64'h4241);
        cfg_put(REG_MARKER_1, 64'h42);
        cfg_put(REG_MARKER_2, 64'h0);
        cfg_put(REG_MARKER_3, 64'h41);
        cfg_put(REG_LENGTHS, 16'h1312);
        cfg_put(REG_COUNT, 3'd4);
        cfg_done();
        queue_word(8'h78, 1'b0, 16'h0000);
        queue_word(8'h41, 1'b0, 16'hFFFF);
        queue_word(8'h42, 1'b1, 16'hFFFF);
        queue_word(8'h41, 1'b0, 16'h0001);
        queue_word(8'h42, 1'b1, 16'h0000);
        queue_word(8'h00, 1'b0, 16'h0000);
        queue_word(8'h00, 1'b0, 16'h0000);
        queue_word(8'h00, 1'b1, 16'h0000);
        queue_word(8'h00, 1'b0, 16'h0000);
        queue_word(8'h00, 1'b1, 16'h0000);
        wait_idle();

        // count above range, lengths above range, identical markers tie
        cfg_put(REG_MARKER_0, '1);
        cfg_put(REG_MARKER_1, '1);
        cfg_put(REG_MARKER_2, '1);
        cfg_put(REG_MARKER_3, '1);
        cfg_put(REG_LENGTHS, 16'hFFFF);
        cfg_put(REG_COUNT, 3'd7);
        cfg_done();
        for (k = 0; k < MARKER_LEN; k++)
            queue_word(8'hFF, k == MARKER_LEN - 1, 16'h0000);
        queue_word(8'hFF, 1'b1, 16'hFFFF);
        wait_idle();

        for (ph = 0; ph < 10; ph++)
        begin
            new_search_setup();
            max_gap = (ph % 3 == 0) ? 0 : $urandom_range(1, 6);
            target = words_queued + 50;
            while (words_queued < target)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) :
                                                  $urandom_range(1, 12);
                case ($urandom_range(0, 7))
                    0: from = POSITION_W'($urandom);
                    1, 2: from = POSITION_W'($urandom_range(0, n));
                    default: from = '0;
                endcase
                queue_text(n, from);
            end
            wait_idle();
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("multi_marker_first_match regression: pass");
        else
            $display("multi_marker_first_match regression: fail");
        $finish;
    end

endmodule
